@@ src/mexp_pkg.sv @@
// shared constants and types of the modular exponentiation unit
`timescale 1ns / 1ps
package mexp_pkg;

    // operand width of base, exponent, modulus and residue
    localparam int OPERAND_BITS = 31;
    // counter width for one pass over the operand bits
    localparam int CNT_W        = $clog2(OPERAND_BITS);
    // stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W   = ((2 * OPERAND_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OPERAND_BITS + 7) / 8) * 8;

    // modulus after reset: all ones
    localparam logic [OPERAND_BITS-1:0] MOD_RESET = '1;
    localparam logic [CNT_W-1:0]        LAST_BIT  = CNT_W'(OPERAND_BITS - 1);

    // request to the modular multiplier
    typedef struct packed {
        logic                    start;
        logic [OPERAND_BITS-1:0] x;     // multiplicand, already below the modulus
        logic [OPERAND_BITS-1:0] y;     // multiplier, scanned msb first
    } t_mm_req;

    // response from the modular multiplier
    typedef struct packed {
        logic                    done;
        logic [OPERAND_BITS-1:0] result;
    } t_mm_rsp;

endpackage

@@ src/modular_exponentiation_unit.sv @@
// top level: square-and-multiply sequencer around a shared modular multiplier
//
//  channel  | direction | handshake                       | payload
//  ---------+-----------+---------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready   | base_value, exponent_value
//  m_axis   | out       | m_axis_tvalid / m_axis_tready   | residue
//  cfg      | in        | i_cfg_we                        | modulus
//
// one transaction takes 32 + popcount(exponent) modular multiplications
// (base reduction, 31 squarings, one multiply per set exponent bit).
// the multiplier is bit-serial, one multiplier bit per cycle.
// a zero modulus answers 0 without using the multiplier.
// reset is synchronous, active low, and restores the modulus to all ones.
// the input is taken only while idle; a finished residue waits in the output
// register while the next transaction is accepted.
`timescale 1ns / 1ps
module modular_exponentiation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [mexp_pkg::OPERAND_BITS-1:0] i_cfg_wdata,  // modulus
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mexp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // base_value, exponent_value
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mexp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // residue
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_SQUARE = 5'b00100,
        S_MULT   = 5'b01000,
        S_HOLD   = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic [OPERAND_BITS-1:0] r_mod;
    logic [OPERAND_BITS-1:0] r_base, n_base;
    logic [OPERAND_BITS-1:0] r_exp, n_exp;
    logic [OPERAND_BITS-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]        r_bit, n_bit;
    t_mm_req                 r_req, n_req;
    logic                    r_out_valid, n_out_valid;
    logic [OPERAND_BITS-1:0] r_out_data, n_out_data;

    t_mm_rsp                 w_rsp;
    logic                    w_in_acc;
    logic                    w_out_acc;
    logic [OPERAND_BITS-1:0] w_one;

    // shared modular multiplier
    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (r_mod),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = r_out_valid && m_axis_tready;
    // 1 mod m
    assign w_one         = (r_mod == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_bit       = r_bit;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_out_valid = w_out_acc ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_exp = s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
                    n_bit = LAST_BIT;
                    if (r_mod == '0) begin
                        n_acc   = '0;
                        n_state = S_HOLD;
                    end else begin
                        // reduce the base as (1 mod m) * base
                        n_acc       = w_one;
                        n_req.start = 1'b1;
                        n_req.x     = w_one;
                        n_req.y     = s_axis_tdata[OPERAND_BITS-1:0];
                        n_state     = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (w_rsp.done) begin
                    n_base      = w_rsp.result;
                    n_req.start = 1'b1;
                    n_req.x     = r_acc;
                    n_req.y     = r_acc;
                    n_state     = S_SQUARE;
                end
            end
            S_SQUARE, S_MULT: begin
                if (w_rsp.done) begin
                    n_acc = w_rsp.result;
                    if (r_state == S_SQUARE && r_exp[OPERAND_BITS-1]) begin
                        // set exponent bit: multiply by the reduced base
                        n_req.start = 1'b1;
                        n_req.x     = r_base;
                        n_req.y     = w_rsp.result;
                        n_state     = S_MULT;
                    end else if (r_bit == '0) begin
                        n_state = S_HOLD;
                    end else begin
                        // next exponent bit
                        n_bit       = r_bit - 1'b1;
                        n_exp       = {r_exp[OPERAND_BITS-2:0], 1'b0};
                        n_req.start = 1'b1;
                        n_req.x     = w_rsp.result;
                        n_req.y     = w_rsp.result;
                        n_state     = S_SQUARE;
                    end
                end
            end
            S_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_RESET;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            r_req.start <= n_req.start;
            r_out_valid <= n_out_valid;
        end
        r_req.x    <= n_req.x;
        r_req.y    <= n_req.y;
        r_base     <= n_base;
        r_exp      <= n_exp;
        r_acc      <= n_acc;
        r_bit      <= n_bit;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OPERAND_BITS){1'b0}}, r_out_data};

`ifndef SYNTH
    // a parked result moves into a free output register in the next cycle
    a_hold_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !r_out_valid) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not delivered from hold");

    // the multiplier only reports done while a product is awaited
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_REDUCE || r_state == S_SQUARE || r_state == S_MULT))
        else $error("unexpected multiplier done");
`endif

endmodule

@@ src/mexp_mulmod.sv @@
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module mexp_mulmod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [mexp_pkg::OPERAND_BITS-1:0] i_mod,
    input  mexp_pkg::t_mm_req i_req,
    output mexp_pkg::t_mm_rsp o_rsp
);
    import mexp_pkg::*;

    localparam int TW = OPERAND_BITS + 2;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [OPERAND_BITS-1:0] r_x, n_x;
    logic [OPERAND_BITS-1:0] r_y, n_y;
    logic [OPERAND_BITS-1:0] r_r, n_r;

    logic [TW-1:0]           w_t;
    logic [TW-1:0]           w_m1;
    logic [TW-1:0]           w_m2;
    logic [OPERAND_BITS-1:0] w_step;

    // one step: r = (2r + ybit*x) mod m, the sum stays below 3m
    always_comb begin
        w_m1 = {2'b00, i_mod};
        w_m2 = {1'b0, i_mod, 1'b0};
        w_t  = {1'b0, r_r, 1'b0} + {2'b00, (r_y[OPERAND_BITS-1] ? r_x : '0)};
        if (w_t >= w_m2) begin
            w_step = OPERAND_BITS'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            w_step = OPERAND_BITS'(w_t - w_m1);
        end else begin
            w_step = OPERAND_BITS'(w_t);
        end
    end

    // sequencing of the steps
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_r    = r_r;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = LAST_BIT;
            n_x    = i_req.x;
            n_y    = i_req.y;
            n_r    = '0;
        end else if (r_busy) begin
            n_r = w_step;
            n_y = {r_y[OPERAND_BITS-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_y   <= n_y;
        r_r   <= n_r;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

`ifndef SYNTH
    // a new product is never requested while one is running
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("mulmod started while busy");

    // the last step ends the run with a done pulse
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("mulmod did not finish after last step");
`endif

endmodule
